FILE: rtl/itbe_pkg.sv
// ----------------------------------------------------------------------------
// itbe_pkg
// Types and constants shared by the I2C target byte engine modules.
// ----------------------------------------------------------------------------
package itbe_pkg;

   localparam logic [6:0] OWN_ADDRESS_RESET = 7'h55;
   localparam int         CSR_DATA_WIDTH    = 32;
   localparam int         CSR_ADDR_WIDTH    = 3;
   localparam logic [3:0] BIT_COUNT_BYTE    = 4'd8;
   localparam logic [3:0] BIT_COUNT_ACK     = 4'd9;

   // Register index of own_address
   localparam logic       REG_OWN_ADDRESS   = 1'b0;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_ADDR    = 3'd1,
      PH_ACK_OUT = 3'd2,
      PH_WRITE   = 3'd3,
      PH_READ    = 3'd4,
      PH_MACK    = 3'd5
   } phase_type;

   typedef enum logic [3:0] {
      EV_NONE     = 4'd0,
      EV_START    = 4'd1,
      EV_STOP     = 4'd2,
      EV_ADDR_W   = 4'd3,
      EV_ADDR_R   = 4'd4,
      EV_MISMATCH = 4'd5,
      EV_BYTE     = 4'd6,
      EV_MACK     = 4'd7,
      EV_MNACK    = 4'd8
   } event_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic [7:0] tx_byte;
   } req_type;

   typedef struct packed {
      logic       sda_pull_low;
      logic [3:0] event_code;
      logic [7:0] rx_data;
   } rsp_type;

   // Bus sample after line-condition classification
   typedef struct packed {
      logic       start;
      logic       stop;
      logic       rise;
      logic       fall;
      logic       sda;
      logic [7:0] tx_byte;
   } item_class_type;

   // Queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: rtl/itbe_front.sv
// ----------------------------------------------------------------------------
// itbe_front
// Accepts bus samples, tracks previous line levels and classifies each item.
// ----------------------------------------------------------------------------
module itbe_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  itbe_pkg::req_type        req_data,
   input  itbe_pkg::queue_status_type q_status,
   output logic                     push,
   output itbe_pkg::item_class_type push_data
);

   logic prev_scl_ff, prev_scl_in;
   logic prev_sda_ff, prev_sda_in;
   logic high;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   assign high = prev_scl_ff && req_data.scl_level;

   always_comb begin
      push_data.start   = high && prev_sda_ff && !req_data.sda_level;
      push_data.stop    = high && !prev_sda_ff && req_data.sda_level;
      push_data.rise    = !prev_scl_ff && req_data.scl_level;
      push_data.fall    = prev_scl_ff && !req_data.scl_level;
      push_data.sda     = req_data.sda_level;
      push_data.tx_byte = req_data.tx_byte;
   end

   // advance line history only on accepted items
   assign prev_scl_in = push ? req_data.scl_level : prev_scl_ff;
   assign prev_sda_in = push ? req_data.sda_level : prev_sda_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_scl_ff <= 1'b1;
         prev_sda_ff <= 1'b1;
      end else begin
         prev_scl_ff <= prev_scl_in;
         prev_sda_ff <= prev_sda_in;
      end
   end

endmodule

FILE: rtl/itbe_queue.sv
// ----------------------------------------------------------------------------
// itbe_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module itbe_queue #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  itbe_pkg::item_class_type   push_data,
   input  logic                       pop,
   output itbe_pkg::item_class_type   pop_data,
   output itbe_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   itbe_pkg::item_class_type entry_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/itbe_back.sv
// ----------------------------------------------------------------------------
// itbe_back
// Protocol FSM: one classified item a cycle unless stalled; registers result.
// ----------------------------------------------------------------------------
module itbe_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [6:0]                 own_address,
   input  itbe_pkg::queue_status_type q_status,
   input  itbe_pkg::item_class_type   item,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output itbe_pkg::rsp_type          rsp_data
);

   itbe_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          shift_ff, shift_in;
   logic [3:0]          count_ff, count_in;
   logic                read_dir_ff, read_dir_in;
   logic                drive_ff, drive_in;
   logic                rsp_valid_ff, rsp_valid_in;
   itbe_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   itbe_pkg::event_type ev;
   logic [7:0]          rx;

   logic [7:0] shift_rx;
   logic [7:0] shift_tx;
   logic [3:0] count_inc;
   logic       count_done;
   logic       addr_match;

   assign pop = !q_status.empty && (!rsp_valid_ff || !rsp_stall);

   assign shift_rx   = {shift_ff[6:0], item.sda};
   assign shift_tx   = {shift_ff[6:0], 1'b0};
   assign count_inc  = count_ff + 4'd1;
   assign count_done = (count_inc >= itbe_pkg::BIT_COUNT_BYTE);
   assign addr_match = (shift_rx[7:1] == own_address);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (item.start) begin
         phase_in = itbe_pkg::PH_ADDR;
      end else if (item.stop) begin
         phase_in = itbe_pkg::PH_IDLE;
      end else begin
         case (phase_ff)
            itbe_pkg::PH_ADDR: begin
               if (item.rise && count_done) begin
                  phase_in = addr_match ? itbe_pkg::PH_ACK_OUT : itbe_pkg::PH_IDLE;
               end
            end
            itbe_pkg::PH_WRITE: begin
               if (item.rise && count_done) begin
                  phase_in = itbe_pkg::PH_ACK_OUT;
               end
            end
            itbe_pkg::PH_ACK_OUT: begin
               if (item.fall && count_ff != itbe_pkg::BIT_COUNT_BYTE) begin
                  phase_in = read_dir_ff ? itbe_pkg::PH_READ : itbe_pkg::PH_WRITE;
               end
            end
            itbe_pkg::PH_READ: begin
               if (item.fall && count_done) begin
                  phase_in = itbe_pkg::PH_MACK;
               end
            end
            itbe_pkg::PH_MACK: begin
               if (item.rise) begin
                  phase_in = item.sda ? itbe_pkg::PH_IDLE : itbe_pkg::PH_ACK_OUT;
               end
            end
            default: begin
               phase_in = itbe_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // datapath and result
   always_comb begin
      shift_in    = shift_ff;
      count_in    = count_ff;
      read_dir_in = read_dir_ff;
      drive_in    = drive_ff;
      ev          = itbe_pkg::EV_NONE;
      rx          = 8'h00;
      if (item.start) begin
         ev       = itbe_pkg::EV_START;
         shift_in = 8'h00;
         count_in = 4'd0;
         drive_in = 1'b0;
      end else if (item.stop) begin
         ev       = itbe_pkg::EV_STOP;
         count_in = 4'd0;
         drive_in = 1'b0;
      end else begin
         case (phase_ff)
            itbe_pkg::PH_ADDR, itbe_pkg::PH_WRITE: begin
               if (item.rise) begin
                  shift_in = shift_rx;
                  count_in = count_inc;
                  if (count_done) begin
                     if (phase_ff == itbe_pkg::PH_WRITE) begin
                        ev       = itbe_pkg::EV_BYTE;
                        rx       = shift_rx;
                        count_in = itbe_pkg::BIT_COUNT_BYTE;
                     end else if (addr_match) begin
                        read_dir_in = shift_rx[0];
                        ev = shift_rx[0] ? itbe_pkg::EV_ADDR_R : itbe_pkg::EV_ADDR_W;
                        count_in = itbe_pkg::BIT_COUNT_BYTE;
                     end else begin
                        ev       = itbe_pkg::EV_MISMATCH;
                        count_in = 4'd0;
                        drive_in = 1'b0;
                     end
                  end
               end
            end
            itbe_pkg::PH_ACK_OUT: begin
               if (item.fall) begin
                  if (count_ff == itbe_pkg::BIT_COUNT_BYTE) begin
                     drive_in = 1'b1;
                     count_in = itbe_pkg::BIT_COUNT_ACK;
                  end else if (read_dir_ff) begin
                     // latch the byte to send and drive its MSB
                     shift_in = item.tx_byte;
                     count_in = 4'd0;
                     drive_in = !item.tx_byte[7];
                  end else begin
                     shift_in = 8'h00;
                     count_in = 4'd0;
                     drive_in = 1'b0;
                  end
               end
            end
            itbe_pkg::PH_READ: begin
               if (item.fall) begin
                  shift_in = shift_tx;
                  count_in = count_inc;
                  drive_in = count_done ? 1'b0 : !shift_tx[7];
               end
            end
            itbe_pkg::PH_MACK: begin
               if (item.rise) begin
                  ev       = item.sda ? itbe_pkg::EV_MNACK : itbe_pkg::EV_MACK;
                  count_in = item.sda ? 4'd0 : itbe_pkg::BIT_COUNT_ACK;
                  drive_in = 1'b0;
               end
            end
            default: begin
               drive_in = 1'b0;
            end
         endcase
      end
   end

   // output register: load on pop, hold while stalled
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.sda_pull_low  = drive_in;
         rsp_data_in.event_code    = ev;
         rsp_data_in.rx_data       = rx;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= itbe_pkg::PH_IDLE;
         shift_ff     <= 8'h00;
         count_ff     <= 4'd0;
         read_dir_ff  <= 1'b0;
         drive_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff    <= phase_in;
            shift_ff    <= shift_in;
            count_ff    <= count_in;
            read_dir_ff <= read_dir_in;
            drive_ff    <= drive_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/i2c_target_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_target_byte_engine
// I2C target with a seven-bit address, one SCL/SDA sample per item.
// ----------------------------------------------------------------------------
//
//   channel  | ports                                  | direction
//   ---------+----------------------------------------+-----------
//   request  | req_valid, req_stall, req_data         | in
//   response | rsp_valid, rsp_stall, rsp_data         | out
//   csr      | csr_psel/penable/pwrite/paddr/pwdata,  | in/out
//            | csr_prdata, csr_pready                 |
//
// One item per cycle sustained while rsp_stall is low; each item gives
// exactly one response item. An accepted item passes through the queue, then
// the state machine, which loads its result into the output register.
// Reset is synchronous; after it the engine is idle, lines read as high and
// own_address is 0x55.
// rsp_stall holds the output register; the queue absorbs QUEUE_DEPTH more
// items before req_stall rises.
// ----------------------------------------------------------------------------
module i2c_target_byte_engine #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  itbe_pkg::req_type                    req_data,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output itbe_pkg::rsp_type                    rsp_data,
   // configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [itbe_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [itbe_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [itbe_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   logic [6:0] own_address_ff, own_address_in;
   logic       csr_write;

   itbe_pkg::queue_status_type q_status;
   itbe_pkg::item_class_type   push_data;
   itbe_pkg::item_class_type   pop_data;
   logic                       push;
   logic                       pop;

   // Register file: one register, own_address at byte address 0.
   // Word index is paddr[2]; the low two bits pick a byte and are ignored.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      own_address_in = own_address_ff;
      if (csr_write && csr_paddr[2] == itbe_pkg::REG_OWN_ADDRESS) begin
         own_address_in = csr_pwdata[6:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == itbe_pkg::REG_OWN_ADDRESS) begin
         csr_prdata = {{(itbe_pkg::CSR_DATA_WIDTH - 7){1'b0}}, own_address_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= itbe_pkg::OWN_ADDRESS_RESET;
      end else begin
         own_address_ff <= own_address_in;
      end
   end

   // Front: edge and START/STOP detection on accepted samples
   itbe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   // Queue: decouples classification from the protocol engine
   itbe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   // Back: address match, ACK slots, byte shift in and out
   itbe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .own_address (own_address_ff),
      .q_status    (q_status),
      .item        (pop_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: rtl/itbe_checker.sv
// ----------------------------------------------------------------------------
// itbe_checker
// Port-level checks for the I2C target byte engine, bound to the top level.
// ----------------------------------------------------------------------------
module itbe_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input itbe_pkg::rsp_type rsp_data
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // input backs up only after output stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> $past(rsp_valid && rsp_stall))
      else $error("req_stall without downstream stall");

   // received data only travels with a byte event
   a_rx_only_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_code != itbe_pkg::EV_BYTE |-> rsp_data.rx_data == 8'h00)
      else $error("rx_data set without byte event");

   // line released on start, stop, mismatch and master nack
   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_code == itbe_pkg::EV_START
                    || rsp_data.event_code == itbe_pkg::EV_STOP
                    || rsp_data.event_code == itbe_pkg::EV_MISMATCH
                    || rsp_data.event_code == itbe_pkg::EV_MNACK)
      |-> !rsp_data.sda_pull_low)
      else $error("SDA pulled low on a releasing event");

   // event codes stay within the defined set
   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.event_code <= itbe_pkg::EV_MNACK)
      else $error("undefined event code");

endmodule

bind i2c_target_byte_engine itbe_checker u_itbe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
